[design/altitude_kalman_fusion_core_assert.svh]
// Assertion macros shared by the altitude fusion modules.
`ifndef ALTITUDE_KALMAN_FUSION_CORE_ASSERT_SVH
`define ALTITUDE_KALMAN_FUSION_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define AKF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define AKF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/akf_pkg.sv]
// Package: types, constants and fixed-point helpers of the altitude filter.
`default_nettype none
package akf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW = 32;
  localparam int CW = 31;
  localparam int DTW = 17;

  localparam logic signed [DW-1:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [DW-1:0] SMIN = 32'sh8000_0000;
  localparam logic signed [DW-1:0] ONE_Q = DW'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [DW-1:0] TEN_Q = DW'(64'sd10 <<< FRAC_BITS);

  localparam logic [1:0] REG_QPOS = 2'd0;
  localparam logic [1:0] REG_QVEL = 2'd1;
  localparam logic [1:0] REG_RBARO = 2'd2;
  localparam logic [1:0] REG_RGPS = 2'd3;
  localparam int CFG_IDX_W = 8;

  localparam logic [CW-1:0] QPOS_RST = 31'd3277;
  localparam logic [CW-1:0] QVEL_RST = 31'd32768;
  localparam logic [CW-1:0] RBARO_RST = 31'd65536;
  localparam logic [CW-1:0] RGPS_RST = 31'd1048576;

  // Datapath micro operations.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_SEED,
    OP_P_ALT,     // alt += mul(spd,dt)
    OP_P_SUM,     // t = sat(p10+p01)
    OP_P_M1,      // a = p00 + mul(dt,t)
    OP_P_DT2,     // t = mul(dt,dt)
    OP_P_M2,      // a += mul(t,p11)
    OP_P_M3,      // t = mul(dt,p11)
    OP_P_FIN,     // commit predict
    OP_U_PREP,    // y, s
    OP_U_DIV0,    // start div p00/s
    OP_U_DIV1,    // start div p10/s
    OP_U_OM,      // om = 1-k0
    OP_U_ALT,
    OP_U_SPD,
    OP_U_C00,
    OP_U_C01,
    OP_U_C10,
    OP_U_C11,
    OP_U_FIN
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_PRED,
    ST_UPD,
    ST_DIVW,
    ST_UPD2,
    ST_OUT
  } ctl_state_e;

  typedef struct packed {
    dp_op_e op;
    logic   gps_sel;   // 1: GPS measurement in update
    logic   load_in;   // capture the accepted request
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic fix;
    logic seeded;
  } dp_sts_t;

  function automatic logic signed [DW-1:0] sat64(input logic signed [63:0] v);
    if (v > 64'(SMAX)) return SMAX;
    if (v < 64'(SMIN)) return SMIN;
    return v[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] qadd(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    return sat64(64'(a) + 64'(b));
  endfunction

  function automatic logic signed [DW-1:0] qsub(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    return sat64(64'(a) - 64'(b));
  endfunction

  // Round a full product to nearest, halves up, and saturate.
  function automatic logic signed [DW-1:0] qround(input logic signed [63:0] p);
    logic signed [63:0] r;
    r = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return sat64(r);
  endfunction

endpackage
`default_nettype wire

[design/akf_if.sv]
// Valid/ready request channel interfaces.
`default_nettype none
interface akf_in_if;
  logic valid;
  logic ready;
  logic [16:0] step_seconds;
  logic signed [31:0] baro_altitude;
  logic signed [31:0] gps_altitude;
  logic gps_fix;
  modport source (output valid, step_seconds, baro_altitude, gps_altitude, gps_fix,
                  input ready);
  modport sink (input valid, step_seconds, baro_altitude, gps_altitude, gps_fix,
                output ready);
endinterface

interface akf_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] fused_altitude;
  logic signed [31:0] vertical_speed;
  logic is_seeded;
  modport source (output valid, fused_altitude, vertical_speed, is_seeded, input ready);
  modport sink (input valid, fused_altitude, vertical_speed, is_seeded, output ready);
endinterface

interface akf_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/akf_div.sv]
// Radix-2 signed fixed-point divider: sat((num << FRAC_BITS) / den).
`default_nettype none
module akf_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic signed [akf_pkg::DW-1:0] num_i,
  input  wire logic signed [akf_pkg::DW-1:0] den_i,
  output logic                              busy_o,
  output logic signed [akf_pkg::DW-1:0]     quo_o
);
  localparam int NW = akf_pkg::DW + akf_pkg::FRAC_BITS;
  localparam int CNW = $clog2(NW + 1);

  logic [NW-1:0] rem_num_q, rem_num_d;  // dividend bits being shifted out
  logic [NW-1:0] quo_q, quo_d;
  logic [akf_pkg::DW:0] rem_q, rem_d;
  logic [akf_pkg::DW-1:0] den_q, den_d;
  logic neg_q, neg_d, zero_q, zero_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [akf_pkg::DW:0] trial;
  logic [NW:0] mag;

  // One quotient bit per cycle, restoring division on magnitudes.
  always_comb begin
    rem_num_d = rem_num_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    neg_d = neg_q;
    zero_d = zero_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = '0;
    if (start_i) begin
      rem_num_d = NW'(num_i[akf_pkg::DW-1] ? -64'(num_i) : 64'(num_i)) << akf_pkg::FRAC_BITS;
      den_d = den_i[akf_pkg::DW-1] ? akf_pkg::DW'(-den_i) : den_i;
      neg_d = num_i[akf_pkg::DW-1] ^ den_i[akf_pkg::DW-1];
      zero_d = (den_i == '0);
      rem_d = '0;
      quo_d = '0;
      cnt_d = CNW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[akf_pkg::DW-1:0], rem_num_q[NW-1]} - {1'b0, den_q};
      rem_num_d = rem_num_q << 1;
      if (!trial[akf_pkg::DW]) begin
        rem_d = trial;
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[akf_pkg::DW-1:0], rem_num_q[NW-1]};
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_num_q <= rem_num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
    zero_q <= zero_d;
  end

  // Sign and saturation of the result.
  always_comb begin
    mag = {1'b0, quo_q};
    if (zero_q) quo_o = '0;
    else if (neg_q) quo_o = akf_pkg::sat64(-64'(mag));
    else quo_o = akf_pkg::sat64(64'(mag));
  end

  assign busy_o = busy_q;
endmodule
`default_nettype wire

[design/akf_datapath.sv]
// Filter state, configuration registers and the shared multiplier.
`default_nettype none
`include "altitude_kalman_fusion_core_assert.svh"
module akf_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire akf_pkg::dp_cmd_t cmd_i,
  output akf_pkg::dp_sts_t      sts_o,
  akf_in_if.sink                in_if,
  akf_cfg_if.sink               cfg_if,
  output logic signed [31:0]    alt_o,
  output logic signed [31:0]    spd_o
);
  typedef logic signed [akf_pkg::DW-1:0] q_t;

  q_t alt_q, spd_q, p00_q, p01_q, p10_q, p11_q;
  q_t n_p00_q, n_p01_q, n_p10_q, n_p11_q;   // results under construction
  q_t t_q, a_q, y_q, s_q, k0_q, k1_q, om_q;
  logic seeded_q, fix_q;
  logic [akf_pkg::DTW-1:0] dt_q;
  q_t baro_q, gps_q;
  logic [akf_pkg::CW-1:0] qpos_q, qvel_q, rbaro_q, rgps_q;
  q_t dt_s, ma, mb, mres, r_sel;
  logic signed [63:0] prod;
  logic div_start;
  q_t div_num, div_q;
  logic div_busy;

  assign cfg_if.ready = 1'b1;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qpos_q <= akf_pkg::QPOS_RST;
      qvel_q <= akf_pkg::QVEL_RST;
      rbaro_q <= akf_pkg::RBARO_RST;
      rgps_q <= akf_pkg::RGPS_RST;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == 8'(akf_pkg::REG_QPOS)) qpos_q <= cfg_if.data[akf_pkg::CW-1:0];
      if (cfg_if.index == 8'(akf_pkg::REG_QVEL)) qvel_q <= cfg_if.data[akf_pkg::CW-1:0];
      if (cfg_if.index == 8'(akf_pkg::REG_RBARO)) rbaro_q <= cfg_if.data[akf_pkg::CW-1:0];
      if (cfg_if.index == 8'(akf_pkg::REG_RGPS)) rgps_q <= cfg_if.data[akf_pkg::CW-1:0];
    end
  end

  assign dt_s = q_t'({15'd0, dt_q});
  assign r_sel = cmd_i.gps_sel ? q_t'({1'b0, rgps_q}) : q_t'({1'b0, rbaro_q});

  // Operand selection for the single multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd_i.op)
      akf_pkg::OP_P_ALT: begin ma = spd_q; mb = dt_s; end
      akf_pkg::OP_P_M1:  begin ma = dt_s;  mb = t_q;  end
      akf_pkg::OP_P_DT2: begin ma = dt_s;  mb = dt_s; end
      akf_pkg::OP_P_M2:  begin ma = t_q;   mb = p11_q; end
      akf_pkg::OP_P_M3:  begin ma = dt_s;  mb = p11_q; end
      akf_pkg::OP_U_ALT: begin ma = k0_q;  mb = y_q;  end
      akf_pkg::OP_U_SPD: begin ma = k1_q;  mb = y_q;  end
      akf_pkg::OP_U_C00: begin ma = om_q;  mb = p00_q; end
      akf_pkg::OP_U_C01: begin ma = om_q;  mb = p01_q; end
      akf_pkg::OP_U_C10: begin ma = k1_q;  mb = p00_q; end
      akf_pkg::OP_U_C11: begin ma = k1_q;  mb = p01_q; end
      default: ;
    endcase
  end

  assign prod = 64'(ma) * 64'(mb);
  assign mres = akf_pkg::qround(prod);

  assign div_start = (cmd_i.op == akf_pkg::OP_U_DIV0) || (cmd_i.op == akf_pkg::OP_U_DIV1);
  assign div_num = (cmd_i.op == akf_pkg::OP_U_DIV0) ? p00_q : p10_q;

  akf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (s_q),
    .busy_o (div_busy),
    .quo_o  (div_q)
  );

  // Filter state; seeded flag is control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q <= 1'b0;
      alt_q <= '0; spd_q <= '0;
      p00_q <= '0; p01_q <= '0; p10_q <= '0; p11_q <= '0;
    end else begin
      unique case (cmd_i.op)
        akf_pkg::OP_SEED: begin
          seeded_q <= 1'b1;
          alt_q <= gps_q; spd_q <= '0;
          p00_q <= akf_pkg::TEN_Q; p01_q <= '0; p10_q <= '0; p11_q <= akf_pkg::TEN_Q;
        end
        akf_pkg::OP_P_ALT: alt_q <= akf_pkg::qadd(alt_q, mres);
        akf_pkg::OP_P_FIN: begin
          p00_q <= akf_pkg::qadd(a_q, q_t'({1'b0, qpos_q}));
          p01_q <= akf_pkg::qadd(p01_q, t_q);
          p10_q <= akf_pkg::qadd(p10_q, t_q);
          p11_q <= akf_pkg::qadd(p11_q, q_t'({1'b0, qvel_q}));
        end
        akf_pkg::OP_U_ALT: alt_q <= akf_pkg::qadd(alt_q, mres);
        akf_pkg::OP_U_SPD: spd_q <= akf_pkg::qadd(spd_q, mres);
        akf_pkg::OP_U_FIN: begin
          p00_q <= n_p00_q; p01_q <= n_p01_q; p10_q <= n_p10_q; p11_q <= n_p11_q;
        end
        default: ;
      endcase
    end
  end

  // Scratch registers of one item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      dt_q <= in_if.step_seconds;
      baro_q <= in_if.baro_altitude;
      gps_q <= in_if.gps_altitude;
      fix_q <= in_if.gps_fix;
    end
    unique case (cmd_i.op)
      akf_pkg::OP_P_SUM: t_q <= akf_pkg::qadd(p10_q, p01_q);
      akf_pkg::OP_P_M1:  a_q <= akf_pkg::qadd(p00_q, mres);
      akf_pkg::OP_P_DT2: t_q <= mres;
      akf_pkg::OP_P_M2:  a_q <= akf_pkg::qadd(a_q, mres);
      akf_pkg::OP_P_M3:  t_q <= mres;
      akf_pkg::OP_U_PREP: begin
        y_q <= akf_pkg::qsub(cmd_i.gps_sel ? gps_q : baro_q, alt_q);
        s_q <= akf_pkg::qadd(p00_q, r_sel);
      end
      akf_pkg::OP_U_DIV1: k0_q <= div_q;
      akf_pkg::OP_U_OM: begin
        k1_q <= div_q;
        om_q <= akf_pkg::qsub(akf_pkg::ONE_Q, k0_q);
      end
      akf_pkg::OP_U_C00: n_p00_q <= mres;
      akf_pkg::OP_U_C01: n_p01_q <= mres;
      akf_pkg::OP_U_C10: n_p10_q <= akf_pkg::qsub(p10_q, mres);
      akf_pkg::OP_U_C11: n_p11_q <= akf_pkg::qsub(p11_q, mres);
      default: ;
    endcase
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.fix = fix_q;
  assign sts_o.seeded = seeded_q;
  assign alt_o = alt_q;
  assign spd_o = spd_q;

  `AKF_ASSERT_IMP(a_seed_once, clk_i, rst_ni, cmd_i.op == akf_pkg::OP_SEED, !seeded_q)
  `AKF_ASSERT_IMP(a_div_idle_start, clk_i, rst_ni, div_start, !div_busy)
  `AKF_ASSERT_NXT(a_seed_sticks, clk_i, rst_ni, seeded_q, seeded_q)
endmodule
`default_nettype wire

[design/akf_ctrl.sv]
// Sequencer that steps the datapath through seed, predict and updates.
`default_nettype none
`include "altitude_kalman_fusion_core_assert.svh"
module akf_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire akf_pkg::dp_sts_t sts_i,
  output akf_pkg::dp_cmd_t      cmd_o
);
  akf_pkg::ctl_state_e state_q, state_d;
  akf_pkg::dp_op_e op_q, op_d;
  logic gps_q, gps_d;

  // Next state and micro-op sequence.
  always_comb begin
    state_d = state_q;
    op_d = op_q;
    gps_d = gps_q;
    unique case (state_q)
      akf_pkg::ST_IDLE: if (in_valid_i) state_d = akf_pkg::ST_SEED;
      akf_pkg::ST_SEED: begin
        state_d = akf_pkg::ST_PRED;
        op_d = akf_pkg::OP_P_ALT;
        gps_d = 1'b0;
      end
      akf_pkg::ST_PRED: begin
        if (op_q == akf_pkg::OP_P_FIN) begin
          state_d = akf_pkg::ST_UPD;
          op_d = akf_pkg::OP_U_PREP;
        end else op_d = akf_pkg::dp_op_e'(op_q + 1'b1);
      end
      akf_pkg::ST_UPD: begin
        if (op_q == akf_pkg::OP_U_DIV0 || op_q == akf_pkg::OP_U_DIV1) begin
          state_d = akf_pkg::ST_DIVW;
        end
        if (op_q == akf_pkg::OP_U_FIN) begin
          if (!gps_q && sts_i.fix) begin
            gps_d = 1'b1;
            op_d = akf_pkg::OP_U_PREP;
          end else state_d = akf_pkg::ST_OUT;
        end else op_d = akf_pkg::dp_op_e'(op_q + 1'b1);
      end
      akf_pkg::ST_DIVW: if (!sts_i.div_busy) state_d = akf_pkg::ST_UPD;
      akf_pkg::ST_OUT: if (out_ready_i) state_d = akf_pkg::ST_IDLE;
      default: state_d = akf_pkg::ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o.op = akf_pkg::OP_NOP;
    cmd_o.gps_sel = gps_q;
    cmd_o.load_in = 1'b0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      akf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      akf_pkg::ST_SEED: if (sts_i.fix && !sts_i.seeded) cmd_o.op = akf_pkg::OP_SEED;
      akf_pkg::ST_PRED, akf_pkg::ST_UPD: cmd_o.op = op_q;
      akf_pkg::ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= akf_pkg::ST_IDLE;
      op_q <= akf_pkg::OP_NOP;
      gps_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q <= op_d;
      gps_q <= gps_d;
    end
  end

  `AKF_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `AKF_ASSERT_NXT(a_accept_goes_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `AKF_ASSERT_IMP(a_gps_only_fix, clk_i, rst_ni, gps_q && state_q == akf_pkg::ST_UPD, sts_i.fix)
endmodule
`default_nettype wire

[design/altitude_kalman_fusion_core.sv]
// Two-state altitude/speed Kalman filter: one item in, one fused estimate out.
// Each request runs a predict and a barometer update, plus a GPS update with a fix;
// each update uses two radix-2 divisions. One item at a time, result held until taken.
// Reset clears the filter state and seeded flag and loads the default registers.
`default_nettype none
module altitude_kalman_fusion_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  akf_in_if.sink    in_if,
  akf_out_if.source out_if,
  akf_cfg_if.sink   cfg_if
);
  akf_pkg::dp_cmd_t cmd;
  akf_pkg::dp_sts_t sts;
  logic signed [31:0] alt, spd;

  akf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  akf_datapath u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .sts_o (sts),
    .in_if (in_if),
    .cfg_if(cfg_if),
    .alt_o (alt),
    .spd_o (spd)
  );

  assign out_if.fused_altitude = alt;
  assign out_if.vertical_speed = spd;
  assign out_if.is_seeded = sts.seeded;
endmodule
`default_nettype wire

[tb/sv/akf_tb_if.sv]
`timescale 1ns / 100ps
// Testbench-side holder for the fused-estimate expectation and input sample record types.
package akf_tb_pkg;
  typedef struct packed {
    logic signed [31:0] fused_altitude;
    logic signed [31:0] vertical_speed;
    logic               is_seeded;
  } estimate_t;

  typedef struct packed {
    logic [16:0]        step_seconds;
    logic signed [31:0] baro_altitude;
    logic signed [31:0] gps_altitude;
    logic               gps_fix;
  } sample_t;
endpackage

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the altitude Kalman fusion core.
module tb;
  logic clk_i;
  logic rst_ni;

  akf_in_if  in_ch ();
  akf_out_if out_ch ();
  akf_cfg_if cfg_ch ();

  altitude_kalman_fusion_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_ch.sink),
    .out_if(out_ch.source),
    .cfg_if(cfg_ch.sink)
  );

  // Filter state of the predictor
  logic signed [31:0] f_alt = '0, f_spd = '0, f_p00 = '0, f_p01 = '0, f_p10 = '0, f_p11 = '0;
  logic               f_seeded = 1'b0;
  logic signed [31:0] q_pos, q_vel, r_baro, r_gps;

  akf_tb_pkg::sample_t   pending_samples[$];
  akf_tb_pkg::estimate_t expected_estimates[$];
  int        mismatch_count = 0;
  int        send_idle_pct;
  int        recv_stall_pct;
  logic      hold_req;
  logic      recv_hold;
  logic      in_sent;

  // Clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Fixed-point helpers, written independently of the package
  function automatic logic signed [31:0] clip(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -66'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [31:0] a, b);
    return clip(66'(a) + 66'(b));
  endfunction

  function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a, b);
    return clip(66'(a) - 66'(b));
  endfunction

  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a, b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b) + 66'sd32768;
    return clip(p >>> 16);
  endfunction

  function automatic logic signed [31:0] fx_div(input logic signed [31:0] n, d);
    logic signed [65:0] num;
    if (d == 0) return 32'sd0;
    num = 66'(n) <<< 16;
    return clip(num / 66'(d));
  endfunction

  task automatic apply_update(input logic signed [31:0] z, input logic signed [31:0] r);
    logic signed [31:0] p00, p01, p10, p11, y, s, k0, k1, om;
    p00 = f_p00; p01 = f_p01; p10 = f_p10; p11 = f_p11;
    y = fx_sub(z, f_alt);
    s = fx_add(p00, r);
    k0 = fx_div(p00, s);
    k1 = fx_div(p10, s);
    om = fx_sub(akf_pkg::ONE_Q, k0);
    f_alt = fx_add(f_alt, fx_mul(k0, y));
    f_spd = fx_add(f_spd, fx_mul(k1, y));
    f_p00 = fx_mul(om, p00);
    f_p01 = fx_mul(om, p01);
    f_p10 = fx_sub(p10, fx_mul(k1, p00));
    f_p11 = fx_sub(p11, fx_mul(k1, p01));
  endtask

  // Advance the filter by one sample and queue the fused estimate
  task automatic fuse_sample(input akf_tb_pkg::sample_t smp);
    logic signed [31:0] dt, p00, p01, p10, p11, acc;
    akf_tb_pkg::estimate_t est;
    dt = 32'(smp.step_seconds);
    if (!f_seeded && smp.gps_fix) begin
      f_alt = smp.gps_altitude;
      f_spd = 0;
      f_p00 = akf_pkg::TEN_Q; f_p01 = 0; f_p10 = 0; f_p11 = akf_pkg::TEN_Q;
      f_seeded = 1'b1;
    end
    p00 = f_p00; p01 = f_p01; p10 = f_p10; p11 = f_p11;
    f_alt = fx_add(f_alt, fx_mul(f_spd, dt));
    acc = fx_add(p00, fx_mul(dt, fx_add(p10, p01)));
    acc = fx_add(acc, fx_mul(fx_mul(dt, dt), p11));
    f_p00 = fx_add(acc, q_pos);
    f_p01 = fx_add(p01, fx_mul(dt, p11));
    f_p10 = fx_add(p10, fx_mul(dt, p11));
    f_p11 = fx_add(p11, q_vel);
    apply_update(smp.baro_altitude, r_baro);
    if (smp.gps_fix) apply_update(smp.gps_altitude, r_gps);
    est.fused_altitude = f_alt;
    est.vertical_speed = f_spd;
    est.is_seeded = f_seeded;
    expected_estimates.push_back(est);
  endtask

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Input acceptance: pops pending samples, predicts on acceptance
  always @(posedge clk_i) begin
    in_sent <= in_ch.valid && in_ch.ready;
    if (in_ch.valid && in_ch.ready) begin
      fuse_sample(pending_samples.pop_front());
    end
  end

  // Drive new requests at the falling edge from the head of the queue
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_sent) begin
      // request still waiting: hold it
    end else if (pending_samples.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
      in_ch.valid <= 1'b1;
      in_ch.step_seconds <= pending_samples[0].step_seconds;
      in_ch.baro_altitude <= pending_samples[0].baro_altitude;
      in_ch.gps_altitude <= pending_samples[0].gps_altitude;
      in_ch.gps_fix <= pending_samples[0].gps_fix;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Long receiver hold-off, counted in its own process
  initial begin
    recv_hold <= 1'b0;
    wait (hold_req);
    @(negedge clk_i);
    recv_hold <= 1'b1;
    repeat (2000) @(negedge clk_i);
    recv_hold <= 1'b0;
  end

  // Receiver ready
  always @(negedge clk_i) begin
    if (recv_hold) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    akf_tb_pkg::estimate_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_estimates.size() == 0) begin
        report_mismatch("unexpected result", out_ch.fused_altitude, 32'sd0);
      end else begin
        want = expected_estimates.pop_front();
        if (out_ch.fused_altitude !== want.fused_altitude)
          report_mismatch("fused_altitude", out_ch.fused_altitude, want.fused_altitude);
        if (out_ch.vertical_speed !== want.vertical_speed)
          report_mismatch("vertical_speed", out_ch.vertical_speed, want.vertical_speed);
        if (out_ch.is_seeded !== want.is_seeded)
          report_mismatch("is_seeded", 32'(out_ch.is_seeded), 32'(want.is_seeded));
      end
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_ch.valid || expected_estimates.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Write one register while the core is idle
  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      8'(akf_pkg::REG_QPOS):  q_pos = {1'b0, val[30:0]};
      8'(akf_pkg::REG_QVEL):  q_vel = {1'b0, val[30:0]};
      8'(akf_pkg::REG_RBARO): r_baro = {1'b0, val[30:0]};
      8'(akf_pkg::REG_RGPS):  r_gps = {1'b0, val[30:0]};
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic akf_tb_pkg::sample_t rand_sample(input int fix_pct);
    akf_tb_pkg::sample_t s;
    logic [31:0] base;
    base = $urandom_range(3, 0) == 0 ? $urandom() :
           32'($signed($urandom_range(2000, 0)) - 1000) <<< 16;
    s.step_seconds = $urandom_range(7, 0) == 0 ? 17'($urandom()) : 17'($urandom_range(65536, 1));
    s.baro_altitude = base + 32'($urandom_range(131072, 0)) - 32'sd65536;
    s.gps_altitude = $urandom_range(7, 0) == 0 ? $urandom() : base + 32'($urandom_range(65536, 0));
    s.gps_fix = $urandom_range(99, 0) < fix_pct;
    return s;
  endfunction

  function automatic akf_tb_pkg::sample_t mk(input logic [16:0] dt, input logic [31:0] b,
                                             input logic [31:0] g, input logic fix);
    akf_tb_pkg::sample_t s;
    s.step_seconds = dt; s.baro_altitude = b; s.gps_altitude = g; s.gps_fix = fix;
    return s;
  endfunction

  task automatic random_phase(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) pending_samples.push_back(rand_sample(60));
    wait_drained();
  endtask

  // Stimulus
  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    q_pos = 32'(akf_pkg::QPOS_RST); q_vel = 32'(akf_pkg::QVEL_RST);
    r_baro = 32'(akf_pkg::RBARO_RST); r_gps = 32'(akf_pkg::RGPS_RST);
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: before seeding, seeding, extremes, odd steps
    pending_samples.push_back(mk(17'd65536, 32'sd1000000, 32'sd5, 1'b0));
    pending_samples.push_back(mk(17'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    pending_samples.push_back(mk(17'd1, 32'h0010_0000, 32'h0010_0000, 1'b1));
    pending_samples.push_back(mk(17'd65536, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
    pending_samples.push_back(mk(17'h1FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
    pending_samples.push_back(mk(17'd0, 32'h0, 32'hFFFF_FFFF, 1'b0));
    pending_samples.push_back(mk(17'd32768, 32'hFFFF_0000, 32'h0, 1'b1));
    wait_drained();
    // Extreme tuning, zero and maximum noise values; bogus indexes ignored
    write_reg(8'(akf_pkg::REG_QPOS), 32'h7FFF_FFFF);
    write_reg(8'(akf_pkg::REG_QVEL), 32'h0);
    write_reg(8'(akf_pkg::REG_RBARO), 32'h0);
    write_reg(8'(akf_pkg::REG_RGPS), 32'hFFFF_FFFF);
    write_reg(8'hFF, 32'h1234_5678);
    write_reg(8'd4, 32'h0);
    pending_samples.push_back(mk(17'd65536, 32'h0001_0000, 32'h0002_0000, 1'b1));
    pending_samples.push_back(mk(17'd100, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
    pending_samples.push_back(mk(17'h10000, 32'h0, 32'h0, 1'b0));
    pending_samples.push_back(mk(17'h15555, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
    wait_drained();
    write_reg(8'(akf_pkg::REG_QPOS), 32'd0);
    write_reg(8'(akf_pkg::REG_QVEL), 32'h7FFF_FFFF);
    write_reg(8'(akf_pkg::REG_RBARO), 32'd1);
    write_reg(8'(akf_pkg::REG_RGPS), 32'd1);
    random_phase(60, 0, 0);

    // Back to typical tuning for the bulk of the run
    write_reg(8'(akf_pkg::REG_QPOS), 32'(akf_pkg::QPOS_RST));
    write_reg(8'(akf_pkg::REG_QVEL), 32'(akf_pkg::QVEL_RST));
    write_reg(8'(akf_pkg::REG_RBARO), 32'(akf_pkg::RBARO_RST));
    write_reg(8'(akf_pkg::REG_RGPS), 32'(akf_pkg::RGPS_RST));
    random_phase(250, 0, 0);
    random_phase(200, 69, 0);
    // Long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    random_phase(200, 0, 69);
    write_reg(8'(akf_pkg::REG_QPOS), 32'($urandom()));
    write_reg(8'(akf_pkg::REG_QVEL), 32'($urandom_range(200000, 0)));
    write_reg(8'(akf_pkg::REG_RBARO), 32'($urandom_range(1 << 22, 1)));
    write_reg(8'(akf_pkg::REG_RGPS), 32'($urandom_range(1 << 24, 1)));
    random_phase(200, 33, 33);
    random_phase(80, 0, 0);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #60ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
